### hw/rtl/pascal_subset_token_scanner_assert.svh
// Assertion macros for the token scanner RTL.
`ifndef PASCAL_SUBSET_TOKEN_SCANNER_ASSERT_SVH
`define PASCAL_SUBSET_TOKEN_SCANNER_ASSERT_SVH
`ifndef SYNTHESIS
`define PST_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PST_ASSERT(label, clk, rst_n, prop, msg)
`define PST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### hw/rtl/pst_pkg.sv
// Shared types, constants and keyword table for the token scanner.
package pst_pkg;

	localparam int KEYWORD_MAX_CHARS_DEF = 5;
	localparam int LENGTH_LIMIT_DEF      = 255;
	localparam int COUNT_WIDTH_DEF       = 16;

	localparam int KW_COUNT    = 9;
	localparam int KW_CHARS    = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int NUM_COUNTED = 6;

	typedef logic [2:0] cls_t;
	localparam cls_t CL_RESERVED = 3'd0;
	localparam cls_t CL_DELIM    = 3'd1;
	localparam cls_t CL_MATH     = 3'd2;
	localparam cls_t CL_REL      = 3'd3;
	localparam cls_t CL_NUMBER   = 3'd4;
	localparam cls_t CL_IDENT    = 3'd5;
	localparam cls_t CL_ERROR    = 3'd6;

	typedef struct packed {
		cls_t       cls;
		logic [3:0] idx;
		logic [7:0] len;
	} tok_t;

	// one queue entry: the tokens caused by one item, one or two of them
	typedef struct packed {
		logic two;
		tok_t tok0;
		tok_t tok1;
	} ent_t;

	function automatic tok_t mk_tok(input cls_t cls, input logic [3:0] idx,
			input logic [7:0] len);
		tok_t t;
		t.cls = cls;
		t.idx = idx;
		t.len = len;
		return t;
	endfunction

	// reserved word text, first character in the lowest byte
	function automatic logic [KW_CHARS*8-1:0] kw_word(input logic [3:0] k);
		logic [KW_CHARS*8-1:0] w;
		unique case (k)
			4'd0: w = {8'h00, 8'h00, 8'h00, "O", "D"};
			4'd1: w = {"N", "I", "G", "E", "B"};
			4'd2: w = {8'h00, "E", "S", "L", "E"};
			4'd3: w = {8'h00, 8'h00, "D", "N", "E"};
			4'd4: w = {8'h00, 8'h00, 8'h00, "F", "I"};
			4'd5: w = {8'h00, "N", "E", "H", "T"};
			4'd6: w = {8'h00, 8'h00, "R", "A", "V"};
			4'd7: w = {"E", "L", "I", "H", "W"};
			4'd8: w = {8'h00, "L", "A", "E", "R"};
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic logic [2:0] kw_len(input logic [3:0] k);
		logic [2:0] n;
		unique case (k)
			4'd0, 4'd4:             n = 3'd2;
			4'd3, 4'd6:             n = 3'd3;
			4'd2, 4'd5, 4'd8:       n = 3'd4;
			4'd1, 4'd7:             n = 3'd5;
			default:                n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

### hw/rtl/pst_front.sv
// Front end: takes characters, tracks the pending lexeme, queues raw tokens.
module pst_front #(
	parameter int KEYWORD_MAX_CHARS = 5,
	parameter int LENGTH_LIMIT      = 255
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          in_kind,
	input  logic [7:0]    in_char,
	input  logic          q_full,
	output logic          q_push,
	output pst_pkg::ent_t q_ent
);
	import pst_pkg::*;

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_WORD   = 3'd1;
	localparam logic [2:0] MODE_NUMBER = 3'd2;
	localparam logic [2:0] MODE_REL    = 3'd3;
	localparam logic [2:0] MODE_COLON  = 3'd4;

	localparam logic [2:0] REL_LT = 3'd0;
	localparam logic [2:0] REL_GT = 3'd3;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam int         PW      = $clog2(KEYWORD_MAX_CHARS);
	localparam logic [7:0] LEN_MAX = 8'(LENGTH_LIMIT);
	localparam logic [7:0] KW_MAX  = 8'(KEYWORD_MAX_CHARS);

	logic [2:0]    mode_q, nxt_mode;
	logic [7:0]    len_q, nxt_len, len_grown;
	logic [2:0]    rel_q, nxt_rel;
	logic [7:0]    prefix_q [KEYWORD_MAX_CHARS];

	logic          acc;
	logic          is_alpha, is_digit;
	logic          kw_hit, kw_ok;
	logic [3:0]    kw_idx;
	logic [KW_CHARS*8-1:0] kw_w;
	tok_t          flush_tok;
	logic          flush_ok;
	tok_t          a_tok, b_tok;
	logic          a_vld, b_vld, use_b;
	logic [2:0]    b_mode;
	logic [7:0]    b_len;
	logic          b_rel_we, b_pre;
	logic [2:0]    b_rel;
	logic          pre_we;
	logic [PW-1:0] pre_idx;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	assign is_alpha = (in_char >= "A" && in_char <= "Z") || (in_char >= "a" && in_char <= "z");
	assign is_digit = in_char >= "0" && in_char <= "9";
	assign len_grown = (len_q < LEN_MAX) ? len_q + 8'd1 : len_q;

	// parallel compare against every reserved word; lowest index wins
	always_comb begin
		kw_hit = 1'b0;
		kw_idx = '0;
		kw_w   = '0;
		kw_ok  = 1'b0;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			kw_w  = kw_word(4'(k));
			kw_ok = len_q == 8'(kw_len(4'(k)));
			for (int j = 0; j < KW_CHARS; j++) begin
				if (j < int'(kw_len(4'(k))) && prefix_q[j] != kw_w[8*j +: 8])
					kw_ok = 1'b0;
			end
			if (kw_ok) begin
				kw_hit = 1'b1;
				kw_idx = 4'(k);
			end
		end
	end

	// token for whatever is pending
	always_comb begin
		flush_ok  = 1'b1;
		flush_tok = mk_tok(CL_ERROR, 4'd0, 8'd1);
		unique case (mode_q)
			MODE_WORD:   flush_tok = kw_hit ? mk_tok(CL_RESERVED, kw_idx, len_q)
			                                : mk_tok(CL_IDENT, 4'd0, len_q);
			MODE_NUMBER: flush_tok = mk_tok(CL_NUMBER, 4'd0, len_q);
			MODE_REL:    flush_tok = mk_tok(CL_REL, {1'b0, rel_q}, 8'd1);
			MODE_COLON:  flush_tok = mk_tok(CL_ERROR, 4'd0, 8'd1);
			default:     flush_ok  = 1'b0;
		endcase
	end

	// character seen with nothing pending
	always_comb begin
		b_vld    = 1'b0;
		b_tok    = mk_tok(CL_ERROR, 4'd0, 8'd1);
		b_mode   = MODE_IDLE;
		b_len    = 8'd0;
		b_rel_we = 1'b0;
		b_rel    = REL_LT;
		b_pre    = 1'b0;
		if (is_alpha) begin
			b_mode = MODE_WORD;
			b_len  = 8'd1;
			b_pre  = 1'b1;
		end else if (is_digit) begin
			b_mode = MODE_NUMBER;
			b_len  = 8'd1;
		end else begin
			unique case (in_char)
				CH_PLUS:  begin b_vld = 1'b1; b_tok = mk_tok(CL_MATH, 4'd0, 8'd1); end
				CH_MINUS: begin b_vld = 1'b1; b_tok = mk_tok(CL_MATH, 4'd1, 8'd1); end
				CH_STAR:  begin b_vld = 1'b1; b_tok = mk_tok(CL_MATH, 4'd2, 8'd1); end
				CH_SLASH: begin b_vld = 1'b1; b_tok = mk_tok(CL_MATH, 4'd3, 8'd1); end
				CH_LT: begin
					b_mode   = MODE_REL;
					b_rel_we = 1'b1;
					b_rel    = REL_LT;
				end
				CH_GT: begin
					b_mode   = MODE_REL;
					b_rel_we = 1'b1;
					b_rel    = REL_GT;
				end
				CH_EQ:    begin b_vld = 1'b1; b_tok = mk_tok(CL_REL, 4'd2, 8'd1); end
				CH_BANG:  begin b_vld = 1'b1; b_tok = mk_tok(CL_REL, 4'd6, 8'd1); end
				CH_COLON: b_mode = MODE_COLON;
				CH_COMMA: begin b_vld = 1'b1; b_tok = mk_tok(CL_DELIM, 4'd0, 8'd1); end
				CH_SEMI:  begin b_vld = 1'b1; b_tok = mk_tok(CL_DELIM, 4'd1, 8'd1); end
				CH_DOT:   begin b_vld = 1'b1; b_tok = mk_tok(CL_DELIM, 4'd3, 8'd1); end
				CH_LPAR:  begin b_vld = 1'b1; b_tok = mk_tok(CL_DELIM, 4'd4, 8'd1); end
				CH_RPAR:  begin b_vld = 1'b1; b_tok = mk_tok(CL_DELIM, 4'd5, 8'd1); end
				CH_SPACE, CH_LF: b_vld = 1'b0;
				default:  b_vld = 1'b1;
			endcase
		end
	end

	// next state and emitted tokens
	always_comb begin
		a_vld    = 1'b0;
		a_tok    = flush_tok;
		use_b    = 1'b0;
		nxt_mode = mode_q;
		nxt_len  = len_q;
		nxt_rel  = rel_q;
		pre_we   = 1'b0;
		pre_idx  = len_q[PW-1:0];
		if (in_kind) begin
			a_vld    = flush_ok;
			nxt_mode = MODE_IDLE;
			nxt_len  = 8'd0;
		end else begin
			unique case (mode_q)
				MODE_WORD: begin
					if (is_alpha || is_digit) begin
						pre_we  = len_q < KW_MAX;
						nxt_len = len_grown;
					end else begin
						a_vld = 1'b1;
						use_b = 1'b1;
					end
				end
				MODE_NUMBER: begin
					if (is_digit) begin
						nxt_len = len_grown;
					end else begin
						a_vld = 1'b1;
						use_b = 1'b1;
					end
				end
				MODE_REL: begin
					a_vld = 1'b1;
					if (rel_q == REL_LT && in_char == CH_EQ) begin
						a_tok    = mk_tok(CL_REL, 4'd1, 8'd2);
						nxt_mode = MODE_IDLE;
					end else if (rel_q == REL_LT && in_char == CH_GT) begin
						a_tok    = mk_tok(CL_REL, 4'd5, 8'd2);
						nxt_mode = MODE_IDLE;
					end else if (rel_q == REL_GT && in_char == CH_EQ) begin
						a_tok    = mk_tok(CL_REL, 4'd4, 8'd2);
						nxt_mode = MODE_IDLE;
					end else begin
						use_b = 1'b1;
					end
				end
				MODE_COLON: begin
					a_vld = 1'b1;
					if (in_char == CH_EQ) begin
						a_tok    = mk_tok(CL_DELIM, 4'd2, 8'd2);
						nxt_mode = MODE_IDLE;
					end else begin
						use_b = 1'b1;
					end
				end
				default: use_b = 1'b1;
			endcase
		end
		if (use_b) begin
			nxt_mode = b_mode;
			nxt_len  = b_len;
			if (b_rel_we)
				nxt_rel = b_rel;
			if (b_pre) begin
				pre_we  = 1'b1;
				pre_idx = '0;
			end
		end
	end

	assign q_push    = acc && (a_vld || (use_b && b_vld));
	assign q_ent.two = a_vld && use_b && b_vld;
	assign q_ent.tok0 = a_vld ? a_tok : b_tok;
	assign q_ent.tok1 = b_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			len_q  <= 8'd0;
			rel_q  <= REL_LT;
		end else if (acc) begin
			mode_q <= nxt_mode;
			len_q  <= nxt_len;
			rel_q  <= nxt_rel;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && pre_we)
			prefix_q[pre_idx] <= in_char;
	end

endmodule

### hw/rtl/pst_fifo.sv
// Small queue of token entries between front and back end.
module pst_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pst_pkg::ent_t wr_ent,
	output logic          full,
	input  logic          pop,
	output pst_pkg::ent_t rd_ent,
	output logic          empty
);
	import pst_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	ent_t        mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   cnt_q;

	assign full   = cnt_q == (AW + 1)'(QUEUE_DEPTH);
	assign empty  = cnt_q == '0;
	assign rd_ent = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_ent;
	end

endmodule

### hw/rtl/pst_back.sv
// Back end: class counters, out reg; one token per cycle if not stalled.
module pst_back #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  pst_pkg::ent_t q_ent,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output pst_pkg::tok_t out_tok,
	output logic [15:0]   out_count,
	output logic          out_last
);
	import pst_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [COUNT_WIDTH-1:0] cnt_q [NUM_COUNTED];
	logic                   sub_q;
	logic                   valid_q;
	tok_t                   tok_q;
	logic [15:0]            count_q;
	logic                   last_q;

	logic                   load, fin, counted;
	tok_t                   tok;
	logic [COUNT_WIDTH-1:0] cur, nxt;
	logic [31:0]            nxt_wide;

	assign load  = !q_empty && (!valid_q || out_ready);
	assign tok   = sub_q ? q_ent.tok1 : q_ent.tok0;
	assign fin   = sub_q || !q_ent.two;
	assign q_pop = load && fin;

	always_comb begin
		cur     = '0;
		counted = 1'b0;
		for (int i = 0; i < NUM_COUNTED; i++) begin
			if (tok.cls == 3'(i)) begin
				cur     = cnt_q[i];
				counted = 1'b1;
			end
		end
		nxt      = (cur == CNT_MAX) ? cur : cur + 1'b1;
		nxt_wide = counted ? 32'(nxt) : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= 1'b0;
			for (int i = 0; i < NUM_COUNTED; i++)
				cnt_q[i] <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sub_q   <= !fin;
				for (int i = 0; i < NUM_COUNTED; i++) begin
					if (tok.cls == 3'(i))
						cnt_q[i] <= nxt;
				end
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q   <= tok;
			count_q <= nxt_wide[15:0];
			last_q  <= fin;
		end
	end

	assign out_valid = valid_q;
	assign out_tok   = tok_q;
	assign out_count = count_q;
	assign out_last  = last_q;

endmodule

### hw/rtl/pascal_subset_token_scanner.sv
// Top level of the Pascal subset token scanner: front end, token queue, back end.
// A token passes through the token queue and then the output register before m_tvalid shows it.
// Throughput: one character per cycle while the token queue is not full; an item giving two tokens
// sends them one after the other, and the four-entry token queue between front and back end absorbs such bursts.
// Reset: arst_n clears scan mode, lexeme length, queue, class counters and m_tvalid.
`include "pascal_subset_token_scanner_assert.svh"

module pascal_subset_token_scanner #(
	parameter int KEYWORD_MAX_CHARS = pst_pkg::KEYWORD_MAX_CHARS_DEF,
	parameter int LENGTH_LIMIT      = pst_pkg::LENGTH_LIMIT_DEF,
	parameter int COUNT_WIDTH       = pst_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tuser,   // [0] kind: 0 character, 1 end of input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [3:0] token_index, [11:4] token_length,
	                               // [27:12] class_count, [31:28] zero
	output logic [2:0]  m_tuser,   // [2:0] token_class
	output logic        m_tlast    // last token caused by the input item
);
	import pst_pkg::*;

	logic        q_push, q_full, q_pop, q_empty;
	ent_t        wr_ent, rd_ent;
	tok_t        out_tok;
	logic [15:0] out_count;

	// front end: classifies each character against the pending lexeme
	pst_front #(
		.KEYWORD_MAX_CHARS(KEYWORD_MAX_CHARS),
		.LENGTH_LIMIT     (LENGTH_LIMIT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_kind (s_tuser),
		.in_char (s_tdata),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_ent   (wr_ent)
	);

	// one entry per item that yields tokens
	pst_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wr_ent(wr_ent),
		.full  (q_full),
		.pop   (q_pop),
		.rd_ent(rd_ent),
		.empty (q_empty)
	);

	// back end: counts per class and drives the output register
	pst_back #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_ent    (rd_ent),
		.q_pop    (q_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_tok  (out_tok),
		.out_count(out_count),
		.out_last (m_tlast)
	);

	assign m_tdata = {4'd0, out_count, out_tok.len, out_tok.idx};
	assign m_tuser = out_tok.cls;

	`PST_ASSERT(a_no_overflow, clk, arst_n, q_push |-> !q_full, "token queue overflow")
	`PST_ASSERT(a_no_underflow, clk, arst_n, q_pop |-> !q_empty, "token queue underflow")
	`PST_ASSERT(a_err_uncounted, clk, arst_n, (m_tvalid && m_tuser == CL_ERROR) |-> (m_tdata[27:12] == 16'd0), "error token with nonzero count")
	`PST_ASSERT(a_len_nonzero, clk, arst_n, m_tvalid |-> (m_tdata[11:4] != 8'd0), "token of zero length")
	`PST_ASSERT_NEXT(a_pair_follows, clk, arst_n, m_tvalid && m_tready && !m_tlast, m_tvalid, "second token of an item missing")

endmodule
